// ===== rtl/esd_pkg.sv =====
// shared types, codes and constants of the escape sequence decoder
package esd_pkg;

    // escape mode codes
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_BSL  = 3'd1;
    localparam logic [2:0] MODE_DEC  = 3'd2;
    localparam logic [2:0] MODE_OCT  = 3'd3;
    localparam logic [2:0] MODE_HEX  = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_ESCAPE = 3'd1;
    localparam logic [2:0] ERR_NO_DEC = 3'd2;
    localparam logic [2:0] ERR_NO_OCT = 3'd3;
    localparam logic [2:0] ERR_NO_HEX = 3'd4;

    // characters
    localparam logic [7:0] CHR_BSL   = 8'h5c;
    localparam logic [7:0] CHR_B     = 8'h62;
    localparam logic [7:0] CHR_E     = 8'h65;
    localparam logic [7:0] CHR_F     = 8'h66;
    localparam logic [7:0] CHR_N     = 8'h6e;
    localparam logic [7:0] CHR_R     = 8'h72;
    localparam logic [7:0] CHR_T     = 8'h74;
    localparam logic [7:0] CHR_V     = 8'h76;
    localparam logic [7:0] CHR_SQ    = 8'h27;
    localparam logic [7:0] CHR_DQ    = 8'h22;
    localparam logic [7:0] CHR_D     = 8'h64;
    localparam logic [7:0] CHR_O     = 8'h6f;
    localparam logic [7:0] CHR_X     = 8'h78;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_SEVEN = 8'h37;
    localparam logic [7:0] CHR_LOW_A = 8'h61;
    localparam logic [7:0] CHR_LOW_F = 8'h66;

    // decoded values of the fixed escapes
    localparam logic [7:0] VAL_B  = 8'h08;
    localparam logic [7:0] VAL_E  = 8'h1b;
    localparam logic [7:0] VAL_F  = 8'h0c;
    localparam logic [7:0] VAL_N  = 8'h0a;
    localparam logic [7:0] VAL_R  = 8'h0d;
    localparam logic [7:0] VAL_T  = 8'h09;
    localparam logic [7:0] VAL_V  = 8'h0b;
    localparam logic [7:0] VAL_MAX = 8'hff;

    // result queue depth
    localparam int RQ_DEPTH = 4;

    // one decoded result
    typedef struct packed {
        logic [7:0] value;
        logic [2:0] err;
        logic       last;
    } esd_result_t;

    // results caused by one input transaction
    typedef struct packed {
        logic [1:0]  count;
        esd_result_t r0;
        esd_result_t r1;
    } esd_batch_t;

    // no-digit error for a number mode
    function automatic logic [2:0] no_digit_err(input logic [2:0] mode);
        logic [2:0] err;
        unique case (mode)
            MODE_DEC: err = ERR_NO_DEC;
            MODE_OCT: err = ERR_NO_OCT;
            default:  err = ERR_NO_HEX;
        endcase
        return err;
    endfunction

endpackage

// ===== rtl/esd_in_if.sv =====
// input channel: source bytes with end-of-input mark
interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ===== rtl/esd_out_if.sv =====
// output channel: decoded bytes with error code and last flag
interface esd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] error_code;
    logic       last;

    modport source (output valid, output out_byte, output error_code, output last,
                    input ready);
    modport sink (input valid, input out_byte, input error_code, input last,
                  output ready);
endinterface

// ===== rtl/esd_step.sv =====
// escape state registers and per-byte decode into up to two results
module esd_step
    import esd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    output esd_batch_t batch
);

    logic [2:0]  mode_reg, mode_next;
    logic [7:0]  acc_reg, acc_next;
    logic        seen_reg, seen_next;

    logic        is_num;
    logic        dig_ok;
    logic [3:0]  dig_val;
    logic [11:0] scaled;
    logic [11:0] sum;

    // candidate results: first phase, fresh byte after a number, flush
    logic        a_v, b_v, e_v;
    esd_result_t a_r, b_r, e_r;

    assign is_num = (mode_reg == MODE_DEC) || (mode_reg == MODE_OCT)
                 || (mode_reg == MODE_HEX);

    // digit recognition for the current base
    always_comb
    begin
        dig_ok  = 1'b0;
        dig_val = 4'd0;
        if (in_byte >= CHR_ZERO && in_byte <= CHR_NINE)
        begin
            dig_val = 4'(in_byte - CHR_ZERO);
            dig_ok  = (mode_reg != MODE_OCT) || (in_byte <= CHR_SEVEN);
        end
        else if (mode_reg == MODE_HEX && in_byte >= CHR_LOW_A && in_byte <= CHR_LOW_F)
        begin
            dig_val = 4'(in_byte - CHR_LOW_A + 8'd10);
            dig_ok  = 1'b1;
        end
    end

    // accumulator times base as shifts and adds
    always_comb
    begin
        case (mode_reg)
            MODE_DEC: scaled = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
            MODE_OCT: scaled = {1'b0, acc_reg, 3'b000};
            default:  scaled = {acc_reg, 4'b0000};
        endcase
        sum = scaled + {8'd0, dig_val};
    end

    // next state and candidate results
    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        seen_next = seen_reg;
        a_v = 1'b0;
        b_v = 1'b0;
        e_v = 1'b0;
        a_r = '0;
        b_r = '0;
        e_r = '0;

        if (mode_reg == MODE_BSL)
        begin
            // escape letter
            mode_next = MODE_IDLE;
            a_v       = 1'b1;
            a_r.err   = ERR_NONE;
            unique case (in_byte)
                CHR_B:  a_r.value = VAL_B;
                CHR_E:  a_r.value = VAL_E;
                CHR_F:  a_r.value = VAL_F;
                CHR_N:  a_r.value = VAL_N;
                CHR_R:  a_r.value = VAL_R;
                CHR_T:  a_r.value = VAL_T;
                CHR_V:  a_r.value = VAL_V;
                CHR_SQ: a_r.value = CHR_SQ;
                CHR_DQ: a_r.value = CHR_DQ;
                CHR_D:
                begin
                    a_v = 1'b0;
                    mode_next = MODE_DEC;
                end
                CHR_O:
                begin
                    a_v = 1'b0;
                    mode_next = MODE_OCT;
                end
                CHR_X:
                begin
                    a_v = 1'b0;
                    mode_next = MODE_HEX;
                end
                default: a_r.err = ERR_ESCAPE;
            endcase
            if (!a_v)
            begin
                acc_next  = 8'd0;
                seen_next = 1'b0;
            end
        end
        else if (is_num && dig_ok)
        begin
            // another digit, saturating
            acc_next  = (sum > 12'd255) ? VAL_MAX : sum[7:0];
            seen_next = 1'b1;
        end
        else
        begin
            // number closed by a non-digit
            if (is_num)
            begin
                a_v       = 1'b1;
                a_r.value = seen_reg ? acc_reg : 8'd0;
                a_r.err   = seen_reg ? ERR_NONE : no_digit_err(mode_reg);
                acc_next  = 8'd0;
                seen_next = 1'b0;
            end
            // fresh byte
            if (in_byte == CHR_BSL)
            begin
                mode_next = MODE_BSL;
            end
            else
            begin
                mode_next = MODE_IDLE;
                b_v       = 1'b1;
                b_r.value = in_byte;
                b_r.err   = ERR_NONE;
            end
        end

        // flush at end of input
        if (end_of_input)
        begin
            if (mode_next == MODE_BSL)
            begin
                e_v     = 1'b1;
                e_r.err = ERR_ESCAPE;
            end
            else if (mode_next == MODE_DEC || mode_next == MODE_OCT
                     || mode_next == MODE_HEX)
            begin
                e_v       = 1'b1;
                e_r.value = seen_next ? acc_next : 8'd0;
                e_r.err   = seen_next ? ERR_NONE : no_digit_err(mode_next);
                acc_next  = 8'd0;
                seen_next = 1'b0;
            end
            mode_next = MODE_IDLE;
        end
    end

    // pack the valid candidates in order
    always_comb
    begin
        batch = '0;
        if (a_v)
        begin
            batch.r0 = a_r;
            batch.r1 = b_v ? b_r : e_r;
        end
        else if (b_v)
        begin
            batch.r0 = b_r;
            batch.r1 = e_r;
        end
        else
        begin
            batch.r0 = e_r;
            batch.r1 = e_r;
        end
        batch.count = 2'({1'b0, a_v} + {1'b0, b_v} + {1'b0, e_v});
        batch.r0.last = (batch.count == 2'd1);
        batch.r1.last = 1'b1;
    end

    // escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= 8'd0;
            seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            seen_reg <= seen_next;
        end
    end

endmodule

// ===== rtl/esd_result_queue.sv =====
// small result queue: takes up to two results per cycle, gives one per cycle while out_ready is high
module esd_result_queue
    import esd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  esd_batch_t  batch,
    output logic        room,
    output logic        out_valid,
    input  logic        out_ready,
    output esd_result_t out_data
);

    localparam int PTR_W = $clog2(RQ_DEPTH);
    localparam int CNT_W = $clog2(RQ_DEPTH + 1);

    esd_result_t        entry_reg [RQ_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [1:0]         n_push;
    logic               pop;

    assign n_push    = push ? batch.count : 2'd0;
    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign room      = (count_reg <= CNT_W'(RQ_DEPTH - 2));
    assign count_next = count_reg + CNT_W'(n_push) - CNT_W'(pop);

    // entry storage
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= batch.r0;
        end
        if (n_push == 2'd2)
        begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= batch.r1;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_push);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/escape_sequence_decoder_core.sv =====
// top level of the escape sequence decoder
//
//  channel | dir | payload                          | handshake
//  in_ch   | in  | in_byte[7:0], end_of_input       | valid/ready
//  out_ch  | out | out_byte[7:0], error_code[2:0],  | valid/ready
//          |     | last                             |
//
// one input transaction per cycle is taken while in_ch.ready is high; it gives
// zero, one or two results; the escape state updates in the accept cycle,
// results are written to a four-entry result queue and leave one per cycle
// while out_ch.ready is high; in_ch.ready is low with under two free entries
// reset (rst_n low) returns to no pending escape and empties the queue
module escape_sequence_decoder_core
    import esd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    esd_in_if.sink    in_ch,
    esd_out_if.source out_ch
);

    esd_batch_t  batch;
    esd_result_t head;
    logic        room;
    logic        accept;

    assign in_ch.ready = room;
    assign accept      = in_ch.valid && room;

    // per-byte decode with escape state
    esd_step u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (in_ch.in_byte),
        .end_of_input (in_ch.end_of_input),
        .batch        (batch)
    );

    // result queue
    esd_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .batch     (batch),
        .room      (room),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (head)
    );

    assign out_ch.out_byte   = head.value;
    assign out_ch.error_code = head.err;
    assign out_ch.last       = head.last;

endmodule
